/* design/sipq_pkg.sv */
// Package for the sorted-insert priority queue core.
// Holds the default depth, field widths, operation and status codes.
// No dependencies.
package sipq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int DATA_W    = 32;
	localparam int PRIO_W    = 16;
	localparam int STATUS_W  = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* design/sorted_insert_priority_queue_core.sv */
// Insert into an empty queue: idle, place, result. Otherwise idle, then one shift
// step per stored entry compared (each compare that moves an entry, plus the one that
// stops the walk, if any), then place and result, with one memory read and one compare
// per step. Remove: memory read, pop, result. Full insert / empty remove: idle, result.
// A result waits in an output register; the next item is taken as soon as the
// sequencer is back in idle. Reset clears head, count, output valid and sequencer;
// entry memory contents are not cleared.
// Depends on sipq_pkg.
module sorted_insert_priority_queue_core #(
	parameter int DEPTH = sipq_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic signed [sipq_pkg::DATA_W-1:0]   item_data,
	input  logic signed [sipq_pkg::PRIO_W-1:0]   item_priority,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [sipq_pkg::STATUS_W-1:0] status,
	output logic signed [sipq_pkg::DATA_W-1:0]   out_data,
	output logic signed [sipq_pkg::PRIO_W-1:0]   out_priority
);
	import sipq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int EW = DATA_W + PRIO_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PLACE,
		S_POP,
		S_RESP
	} state_t;

	state_t state_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] k_q;

	logic signed [DATA_W-1:0] new_data_q;
	logic signed [PRIO_W-1:0] new_prio_q;

	logic [STATUS_W-1:0]      res_status_q;
	logic signed [DATA_W-1:0] res_data_q;
	logic signed [PRIO_W-1:0] res_prio_q;

	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic signed [PRIO_W-1:0] out_prio_q;

	// entry memory: one write, one registered read per cycle
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_idx;
	logic [AW-1:0] tail_prev;
	logic [AW-1:0] pos_prev;
	logic [AW-1:0] pos_prev2;
	logic [AW-1:0] head_next;
	logic          in_xfer;
	logic          out_free;
	logic          move_up;
	logic signed [PRIO_W-1:0] rd_prio;

	function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] i);
		logic [AW-1:0] r;
		if (i == '0)
			r = AW'(DEPTH - 1);
		else
			r = i - 1'b1;
		return r;
	endfunction

	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign tail_prev = wrap_prev(tail_idx);
	assign pos_prev  = wrap_prev(pos_q);
	assign pos_prev2 = wrap_prev(pos_prev);
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign rd_prio  = rd_q[PRIO_W-1:0];
	// shared compare: new entry goes ahead of the stored one only if strictly smaller
	assign move_up  = new_prio_q < rd_prio;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_addr = pos_prev2;
		if (state_q == S_IDLE)
			rd_addr = (func == FUNC_REMOVE) ? head_q : tail_prev;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = {new_data_q, new_prio_q};
		unique case (state_q)
			S_SHIFT: begin
				if (move_up) begin
					wr_en   = 1'b1;
					wr_data = rd_q;
				end
			end
			S_PLACE: wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_RESP the output register is reloaded below instead
			if (out_valid_q && out_ready && state_q != S_RESP)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						new_data_q   <= item_data;
						new_prio_q   <= item_priority;
						res_status_q <= ST_OK;
						res_data_q   <= '0;
						res_prio_q   <= '0;
						pos_q        <= tail_idx;
						k_q          <= count_q;
						if (func == FUNC_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end else if (count_q == '0) begin
								state_q <= S_PLACE;
							end else begin
								state_q <= S_SHIFT;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_POP;
							end
						end
					end
				end
				S_SHIFT: begin
					// rd_q holds the entry just ahead of pos_q
					if (move_up) begin
						pos_q <= pos_prev;
						k_q   <= k_q - 1'b1;
						if (k_q == CW'(1))
							state_q <= S_PLACE;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_RESP;
				end
				S_POP: begin
					res_data_q <= rd_q[EW-1:PRIO_W];
					res_prio_q <= rd_prio;
					head_q     <= head_next;
					count_q    <= count_q - 1'b1;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						out_data_q  <= res_data_q;
						out_prio_q  <= res_prio_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;

endmodule

/* tb/sv/sorted_insert_priority_queue_core_tb.sv */
// Testbench for sorted_insert_priority_queue_core: directed, backpressure and random phases,
// checked against an in-bench sorted circular-store model of the queue.
// Depends on sipq_pkg and the core module.
module sorted_insert_priority_queue_core_tb;
	import sipq_pkg::*;

	localparam int QDEPTH      = DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 4 * QDEPTH + 12;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} qresult_t;

	typedef enum int {PRIO_TIES, PRIO_FULL, PRIO_EXTREME} prio_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	logic signed [DATA_W-1:0] item_data;
	logic signed [PRIO_W-1:0] item_priority;
	logic out_valid;
	logic out_ready;
	logic [STATUS_W-1:0] status;
	logic signed [DATA_W-1:0] out_data;
	logic signed [PRIO_W-1:0] out_priority;

	// queue model state
	logic signed [DATA_W-1:0] model_data [QDEPTH];
	logic signed [PRIO_W-1:0] model_prio [QDEPTH];
	int unsigned model_head;
	int unsigned model_count;

	qresult_t pending_results [$];
	int fail_count = 0;
	int quiet_cycles = 0;
	bit idle_on;
	int hold_requests;

	sorted_insert_priority_queue_core #(
		.DEPTH(QDEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.item_data    (item_data),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_data     (out_data),
		.out_priority (out_priority)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic qresult_t queue_model_apply(logic f, logic signed [DATA_W-1:0] d,
			logic signed [PRIO_W-1:0] p);
		qresult_t r;
		int unsigned pos;
		int unsigned prev;
		int unsigned k;
		bit moving;
		r = '0;
		r.status = ST_OK;
		if (f == FUNC_INSERT) begin
			if (model_count >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = (model_head + model_count) % QDEPTH;
				k = model_count;
				moving = 1'b1;
				// shift larger entries one slot toward the tail; equal ones stay ahead
				while (k > 0 && moving) begin
					prev = (pos == 0) ? QDEPTH - 1 : pos - 1;
					if (p < model_prio[prev]) begin
						model_data[pos] = model_data[prev];
						model_prio[pos] = model_prio[prev];
						pos = prev;
						k--;
					end else begin
						moving = 1'b0;
					end
				end
				model_data[pos] = d;
				model_prio[pos] = p;
				model_count++;
			end
		end else begin
			if (model_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.data = model_data[model_head];
				r.prio = model_prio[model_head];
				model_head = (model_head + 1) % QDEPTH;
				model_count--;
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [PRIO_W-1:0] rand_prio(prio_mode_t mode);
		logic signed [PRIO_W-1:0] p;
		case (mode)
			PRIO_TIES: begin
				p = PRIO_W'($signed($urandom_range(0, 6)) - 3);
			end
			PRIO_EXTREME: begin
				case ($urandom_range(0, 5))
					0: p = 16'sh8000;
					1: p = 16'sh8001;
					2: p = -16'sd1;
					3: p = 16'sd0;
					4: p = 16'sh7ffe;
					default: p = 16'sh7fff;
				endcase
			end
			default: begin
				p = PRIO_W'($urandom());
			end
		endcase
		return p;
	endfunction

	task automatic send_cmd(logic f, logic signed [DATA_W-1:0] d, logic signed [PRIO_W-1:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		item_data     <= d;
		item_priority <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(queue_model_apply(f, d, p));
	endtask

	task automatic report_fail(string what, qresult_t exp_r, qresult_t got_r);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: exp status %0d data %0d prio %0d, got status %0d data %0d prio %0d",
				what, exp_r.status, exp_r.data, exp_r.prio,
				got_r.status, got_r.data, got_r.prio);
	endtask

	// receiver: checks each result transfer and drives out_ready
	initial begin
		qresult_t got_r;
		qresult_t exp_r;
		int rx_gap;
		int stall_left;
		int holds_done;
		out_ready = 1'b0;
		rx_gap = 0;
		stall_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got_r.status = status;
				got_r.data   = out_data;
				got_r.prio   = out_priority;
				if (pending_results.size() == 0) begin
					report_fail("unexpected result", '0, got_r);
				end else begin
					exp_r = pending_results.pop_front();
					if (got_r.status !== exp_r.status || got_r.data !== exp_r.data ||
							got_r.prio !== exp_r.prio)
						report_fail("mismatch", exp_r, got_r);
				end
			end
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_empty_remove();
		send_cmd(FUNC_REMOVE, 32'sh1234_5678, 16'sh7fff);
		send_cmd(FUNC_REMOVE, -32'sd1, 16'sh8000);
	endtask

	// fills with extremes and ties, then one insert more than fits
	task automatic test_fill_and_overflow();
		send_cmd(FUNC_INSERT, 32'sh7fff_ffff, 16'sh7fff);
		send_cmd(FUNC_INSERT, 32'sh8000_0000, 16'sh8000);
		send_cmd(FUNC_INSERT, 32'sh0000_0001, 16'sd0);
		send_cmd(FUNC_INSERT, 32'sh0000_0002, 16'sd0);
		send_cmd(FUNC_INSERT, -32'sd1, -16'sd1);
		send_cmd(FUNC_INSERT, 32'sh0, 16'sd1);
		send_cmd(FUNC_INSERT, 32'sh5555_aaaa, 16'sh7fff);
		send_cmd(FUNC_INSERT, 32'shaaaa_5555, 16'sd0);
		send_cmd(FUNC_INSERT, 32'shdead_beef, 16'sh8000);
	endtask

	task automatic test_drain();
		repeat (QDEPTH + 1) send_cmd(FUNC_REMOVE, $urandom(), PRIO_W'($urandom()));
	endtask

	// output held off while inputs are offered back to back, with no idle gaps
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_requests++;
		repeat (QDEPTH + 4) send_cmd(FUNC_INSERT, $urandom(), rand_prio(PRIO_TIES));
		repeat (QDEPTH + 4) send_cmd(FUNC_REMOVE, $urandom(), PRIO_W'($urandom()));
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		int seg;
		int n;
		int ins_pct;
		prio_mode_t pmode;
		for (seg = 0; seg < 14; seg++) begin
			idle_on = (seg % 4 != 3);
			case (seg % 3)
				0: ins_pct = 75;
				1: ins_pct = 50;
				default: ins_pct = 30;
			endcase
			pmode = prio_mode_t'($urandom_range(0, 2));
			for (n = 0; n < 100; n++) begin
				if ($urandom_range(0, 99) < ins_pct)
					send_cmd(FUNC_INSERT, $urandom(), rand_prio(pmode));
				else
					send_cmd(FUNC_REMOVE, $urandom(), PRIO_W'($urandom()));
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = FUNC_INSERT;
		item_data     = '0;
		item_priority = '0;
		idle_on       = 1'b1;
		hold_requests = 0;
		model_head    = 0;
		model_count   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_remove();
		test_fill_and_overflow();
		test_drain();
		test_backpressure();
		test_random();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
